FILE: src/kmer_markov_composition_vector_assert.svh
// Assertion helpers shared by the block's modules.
`ifndef KMER_MARKOV_COMPOSITION_VECTOR_ASSERT_SVH
`define KMER_MARKOV_COMPOSITION_VECTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define KMCV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kmcv assertion failed");

// Next-cycle implication, disabled during reset.
`define KMCV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kmcv assertion failed");

`endif

FILE: src/kmcv_pkg.sv
`timescale 1ns / 1ps
package kmcv_pkg;

  localparam int ALPHABET_BITS = 2;
  localparam int MAX_K         = 8;
  localparam int MIN_K         = 3;
  localparam int CFG_W         = 4;
  localparam int KW            = MAX_K * ALPHABET_BITS;
  localparam int KM1W          = (MAX_K - 1) * ALPHABET_BITS;
  localparam int KM2W          = (MAX_K - 2) * ALPHABET_BITS;
  localparam int FILL_W        = $clog2(MAX_K + 1);
  localparam int CNT_W         = 32;
  localparam int BIG_WORDS     = 6;
  localparam int BIGW          = BIG_WORDS * CNT_W;
  localparam int WORD_W        = $clog2(BIG_WORDS);
  localparam int QBITS         = 33;
  localparam int QCNT_W        = $clog2(QBITS + 1);
  localparam int FRAC_BITS     = 16;

  localparam logic [CFG_W-1:0]  K_RESET  = CFG_W'(MIN_K);
  localparam logic [CNT_W-1:0]  CV_MAX   = 32'h7FFF_FFFF;
  localparam logic [CNT_W-1:0]  ONE_Q16  = 32'h0001_0000;
  localparam logic [QBITS-1:0]  Q_SAT    = QBITS'(CV_MAX) + QBITS'(ONE_Q16);

  localparam logic [1:0] CMD_SYMBOL = 2'd0;
  localparam logic [1:0] CMD_EOG    = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLR_WR, OP_ACCEPT, OP_SYM_WR, OP_LOAD, OP_MUL_WORD,
    OP_SAVE_NUM, OP_DIV_LD, OP_DIV_CHK, OP_DIV_STEP, OP_FINISH
  } dp_op_t;

  typedef enum logic [2:0] {
    SEL_T0, SEL_T1, SEL_T2, SEL_CA, SEL_CB, SEL_CM, SEL_N
  } opnd_sel_t;

  typedef struct packed {
    dp_op_t            op;
    opnd_sel_t         sel;
    logic [WORD_W-1:0] word;
    logic [KW-1:0]     addr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cv_valid;
    logic num_zero;
    logic div_over;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [KW-1:0] low_mask(input logic [CFG_W-1:0] len);
    logic [KW:0] m;
    m = ((KW + 1)'(1) << (len * ALPHABET_BITS)) - (KW + 1)'(1);
    return m[KW-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + CNT_W'(1);
  endfunction

endpackage

FILE: src/kmcv_ctrl.sv
`timescale 1ns / 1ps
`include "kmer_markov_composition_vector_assert.svh"
module kmcv_ctrl
  import kmcv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic [1:0] in_cmd,
  input  dp_stat_t  stat,
  output logic      in_stall,
  output ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SYM_WR, S_Q_CHK, S_MUL, S_SAVE, S_LOAD2,
    S_DIV_LD, S_DIV_CHK, S_DIV, S_FINISH
  } state_t;

  localparam logic [2:0] MUL_NUM_LAST = 3'd2;
  localparam logic [2:0] MUL_LAST     = 3'd5;

  state_t              state_r, state_nxt;
  logic [KW-1:0]       clr_r, clr_nxt;
  logic [WORD_W-1:0]   word_r, word_nxt;
  logic [2:0]          mul_r, mul_nxt;
  logic [QCNT_W-1:0]   qbit_r, qbit_nxt;
  opnd_sel_t           mul_sel;

  // Multiplier order: numerator T2, cb, ca onto T0; denominator T1, cm, n onto T1.
  always_comb begin
    unique case (mul_r)
      3'd0:    mul_sel = SEL_T2;
      3'd1:    mul_sel = SEL_CB;
      3'd2:    mul_sel = SEL_CA;
      3'd3:    mul_sel = SEL_T1;
      3'd4:    mul_sel = SEL_CM;
      default: mul_sel = SEL_N;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    word_nxt  = word_r;
    mul_nxt   = mul_r;
    qbit_nxt  = qbit_r;
    cmd.op    = OP_NONE;
    cmd.sel   = SEL_T0;
    cmd.word  = word_r;
    cmd.addr  = clr_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op  = OP_CLR_WR;
        clr_nxt = clr_r + KW'(1);
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          unique case (in_cmd)
            CMD_SYMBOL: state_nxt = S_SYM_WR;
            CMD_QUERY:  state_nxt = S_Q_CHK;
            CMD_CLEAR: begin
              state_nxt = S_CLEAR;
              clr_nxt   = '0;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SYM_WR: begin
        cmd.op    = OP_SYM_WR;
        state_nxt = S_IDLE;
      end
      S_Q_CHK: begin
        cmd.op    = OP_LOAD;
        cmd.sel   = SEL_T0;
        mul_nxt   = '0;
        word_nxt  = '0;
        state_nxt = stat.cv_valid ? S_MUL : S_FINISH;
      end
      S_MUL: begin
        cmd.op  = OP_MUL_WORD;
        cmd.sel = mul_sel;
        if (word_r == WORD_W'(BIG_WORDS - 1)) begin
          word_nxt = '0;
          mul_nxt  = mul_r + 3'd1;
          if (mul_r == MUL_NUM_LAST) state_nxt = S_SAVE;
          else if (mul_r == MUL_LAST) state_nxt = S_DIV_LD;
        end else begin
          word_nxt = word_r + WORD_W'(1);
        end
      end
      S_SAVE: begin
        cmd.op    = OP_SAVE_NUM;
        state_nxt = S_LOAD2;
      end
      S_LOAD2: begin
        cmd.op    = OP_LOAD;
        cmd.sel   = SEL_T1;
        state_nxt = stat.num_zero ? S_FINISH : S_MUL;
      end
      S_DIV_LD: begin
        cmd.op    = OP_DIV_LD;
        state_nxt = S_DIV_CHK;
      end
      S_DIV_CHK: begin
        cmd.op    = OP_DIV_CHK;
        qbit_nxt  = '0;
        state_nxt = stat.div_over ? S_FINISH : S_DIV;
      end
      S_DIV: begin
        cmd.op   = OP_DIV_STEP;
        qbit_nxt = qbit_r + QCNT_W'(1);
        if (qbit_r == QCNT_W'(QBITS - 1)) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!stat.out_busy) begin
          cmd.op    = OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      word_r  <= '0;
      mul_r   <= '0;
      qbit_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      word_r  <= word_nxt;
      mul_r   <= mul_nxt;
      qbit_r  <= qbit_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  `KMCV_ASSERT_NEXT(a_query_starts, clk, rst_n, (state_r == S_IDLE) && in_valid && (in_cmd == CMD_QUERY), state_r == S_Q_CHK)
  `KMCV_ASSERT_IMPL(a_word_range, clk, rst_n, state_r == S_MUL, word_r < WORD_W'(BIG_WORDS))
  `KMCV_ASSERT_IMPL(a_qbit_range, clk, rst_n, state_r == S_DIV, qbit_r < QCNT_W'(QBITS))

endmodule

FILE: src/kmcv_dp.sv
`timescale 1ns / 1ps
`include "kmer_markov_composition_vector_assert.svh"
module kmcv_dp
  import kmcv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  input  logic [CFG_W-1:0]        cfg_kmer_length,
  input  logic [1:0]              in_cmd,
  input  logic [1:0]              in_symbol,
  input  logic [15:0]             in_kmer_index,
  input  logic                    out_stall,
  input  ctrl_cmd_t               cmd,
  output dp_stat_t                stat,
  output logic                    out_valid,
  output logic [CNT_W-1:0]        out_kmer_count,
  output logic signed [CNT_W-1:0] out_cv_value,
  output logic                    out_cv_valid
);

  logic [CNT_W-1:0] mem_k   [2**KW];
  logic [CNT_W-1:0] mem_km1 [2**KM1W];
  logic [CNT_W-1:0] mem_km2 [2**KM2W];

  logic [CFG_W-1:0]  klen_r, k_eff, k_m1, k_m2;
  logic [KW-1:0]     win_r, win_nxt, q_idx;
  logic [FILL_W-1:0] fill_r;
  logic [CNT_W-1:0]  tot_r [3];
  logic              out_valid_r;

  logic [ALPHABET_BITS-1:0] sym_ext;
  logic [KW-1:0]     ra_k;
  logic [KM1W-1:0]   ra_a, ra_b;
  logic [KM2W-1:0]   ra_m;
  logic              rd_en, is_sym;
  logic [CNT_W-1:0]  rd_k_r, rd_km1a_r, rd_km1b_r, rd_km2_r;
  logic [KW-1:0]     idx_k_r;
  logic [KM1W-1:0]   idx_a_r;
  logic [KM2W-1:0]   idx_m_r;

  logic              we_k, we_km1, we_km2;
  logic [KW-1:0]     wa_k;
  logic [KM1W-1:0]   wa_km1;
  logic [KM2W-1:0]   wa_km2;
  logic [CNT_W-1:0]  wd_k, wd_km1, wd_km2;

  logic [BIGW-1:0]   acc_r, num_r, rem_r, dsh_r, dsh_s;
  logic [BIGW:0]     diff;
  logic [CNT_W-1:0]  carry_r, opnd, acc_word, carry_in;
  logic [2*CNT_W-1:0] prod;
  logic [QBITS-1:0]  q_r;
  logic              over_r;
  logic [CNT_W-1:0]  cv_calc;
  logic [CNT_W-1:0]  cnt_r, cv_value_r;
  logic              cv_valid_r;

  // effective word length, clamped to the built range
  always_comb begin
    if (klen_r < CFG_W'(MIN_K))      k_eff = CFG_W'(MIN_K);
    else if (klen_r > CFG_W'(MAX_K)) k_eff = CFG_W'(MAX_K);
    else                             k_eff = klen_r;
    k_m1 = k_eff - CFG_W'(1);
    k_m2 = k_eff - CFG_W'(2);
  end

  assign sym_ext = ALPHABET_BITS'(in_symbol);
  assign win_nxt = {win_r[KW-ALPHABET_BITS-1:0], sym_ext};
  assign q_idx   = KW'(in_kmer_index) & low_mask(k_eff);
  assign is_sym  = (in_cmd == CMD_SYMBOL);
  assign rd_en   = (cmd.op == OP_ACCEPT);

  always_comb begin
    if (is_sym) begin
      ra_k = win_nxt & low_mask(k_eff);
      ra_a = KM1W'(win_nxt & low_mask(k_m1));
      ra_m = KM2W'(win_nxt & low_mask(k_m2));
    end else begin
      ra_k = q_idx;
      ra_a = KM1W'(q_idx >> ALPHABET_BITS);
      ra_m = KM2W'((q_idx >> ALPHABET_BITS) & low_mask(k_m2));
    end
    ra_b = KM1W'(q_idx & low_mask(k_m1));
  end

  // write side: clearing sweep or saturating increment
  always_comb begin
    if (cmd.op == OP_CLR_WR) begin
      we_k   = 1'b1;
      we_km1 = 1'b1;
      we_km2 = 1'b1;
      wa_k   = cmd.addr;
      wa_km1 = KM1W'(cmd.addr);
      wa_km2 = KM2W'(cmd.addr);
      wd_k   = '0;
      wd_km1 = '0;
      wd_km2 = '0;
    end else begin
      we_k   = (cmd.op == OP_SYM_WR) && (CFG_W'(fill_r) >= k_eff);
      we_km1 = (cmd.op == OP_SYM_WR) && (CFG_W'(fill_r) >= k_m1);
      we_km2 = (cmd.op == OP_SYM_WR) && (CFG_W'(fill_r) >= k_m2);
      wa_k   = idx_k_r;
      wa_km1 = idx_a_r;
      wa_km2 = idx_m_r;
      wd_k   = sat_inc(rd_k_r);
      wd_km1 = sat_inc(rd_km1a_r);
      wd_km2 = sat_inc(rd_km2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (we_k) mem_k[wa_k] <= wd_k;
    if (rd_en) rd_k_r <= mem_k[ra_k];
  end

  always_ff @(posedge clk) begin
    if (we_km1) mem_km1[wa_km1] <= wd_km1;
    if (rd_en) begin
      rd_km1a_r <= mem_km1[ra_a];
      rd_km1b_r <= mem_km1[ra_b];
    end
  end

  always_ff @(posedge clk) begin
    if (we_km2) mem_km2[wa_km2] <= wd_km2;
    if (rd_en) rd_km2_r <= mem_km2[ra_m];
  end

  // operand for load and multiply
  always_comb begin
    unique case (cmd.sel)
      SEL_T0:  opnd = tot_r[0];
      SEL_T1:  opnd = tot_r[1];
      SEL_T2:  opnd = tot_r[2];
      SEL_CA:  opnd = rd_km1b_r;
      SEL_CB:  opnd = rd_km1a_r;
      SEL_CM:  opnd = rd_km2_r;
      default: opnd = rd_k_r;
    endcase
  end

  assign acc_word = acc_r[cmd.word*CNT_W +: CNT_W];
  assign carry_in = (cmd.word == '0) ? '0 : carry_r;
  assign prod     = (2*CNT_W)'(acc_word) * (2*CNT_W)'(opnd) + (2*CNT_W)'(carry_in);
  assign dsh_s    = dsh_r >> 1;
  assign diff     = {1'b0, rem_r} - {1'b0, dsh_s};
  assign cv_calc  = (q_r > Q_SAT) ? CV_MAX : CNT_W'(q_r - QBITS'(ONE_Q16));

  assign stat.cv_valid = (rd_km1a_r != '0) && (rd_km1b_r != '0);
  assign stat.num_zero = (num_r == '0);
  assign stat.div_over = (rem_r >= dsh_r);
  assign stat.out_busy = out_valid_r && out_stall;

  // control state: config, window, totals, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r      <= K_RESET;
      win_r       <= '0;
      fill_r      <= '0;
      tot_r[0]    <= '0;
      tot_r[1]    <= '0;
      tot_r[2]    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) klen_r <= cfg_kmer_length;
      if (cmd.op == OP_ACCEPT) begin
        unique case (in_cmd)
          CMD_SYMBOL: begin
            win_r <= win_nxt;
            if (fill_r < FILL_W'(MAX_K)) fill_r <= fill_r + FILL_W'(1);
          end
          CMD_EOG: begin
            win_r  <= '0;
            fill_r <= '0;
          end
          CMD_CLEAR: begin
            win_r    <= '0;
            fill_r   <= '0;
            tot_r[0] <= '0;
            tot_r[1] <= '0;
            tot_r[2] <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.op == OP_SYM_WR) begin
        if (CFG_W'(fill_r) >= k_eff) tot_r[0] <= sat_inc(tot_r[0]);
        if (CFG_W'(fill_r) >= k_m1)  tot_r[1] <= sat_inc(tot_r[1]);
        if (CFG_W'(fill_r) >= k_m2)  tot_r[2] <= sat_inc(tot_r[2]);
      end
      if (cmd.op == OP_FINISH) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // arithmetic and payload registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      idx_k_r <= ra_k;
      idx_a_r <= ra_a;
      idx_m_r <= ra_m;
    end
    unique case (cmd.op)
      OP_LOAD: acc_r <= BIGW'(opnd);
      OP_MUL_WORD: begin
        acc_r[cmd.word*CNT_W +: CNT_W] <= prod[CNT_W-1:0];
        carry_r <= prod[2*CNT_W-1:CNT_W];
      end
      OP_SAVE_NUM: num_r <= acc_r;
      OP_DIV_LD: begin
        rem_r <= acc_r << FRAC_BITS;
        dsh_r <= num_r << QBITS;
      end
      OP_DIV_CHK: over_r <= (rem_r >= dsh_r);
      OP_DIV_STEP: begin
        dsh_r <= dsh_s;
        if (!diff[BIGW]) rem_r <= diff[BIGW-1:0];
        q_r <= {q_r[QBITS-2:0], !diff[BIGW]};
      end
      OP_FINISH: begin
        cnt_r      <= rd_k_r;
        cv_valid_r <= stat.cv_valid;
        if (!stat.cv_valid)                     cv_value_r <= '0;
        else if (stat.num_zero || over_r)       cv_value_r <= CV_MAX;
        else                                    cv_value_r <= cv_calc;
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_kmer_count = cnt_r;
  assign out_cv_value   = cv_value_r;
  assign out_cv_valid   = cv_valid_r;

  `KMCV_ASSERT_IMPL(a_finish_free, clk, rst_n, cmd.op == OP_FINISH, !out_valid_r || !out_stall)
  `KMCV_ASSERT_IMPL(a_sym_fill, clk, rst_n, cmd.op == OP_SYM_WR, fill_r != '0)
  `KMCV_ASSERT_IMPL(a_cv_zero, clk, rst_n, out_valid_r && !cv_valid_r, cv_value_r == '0)

endmodule

FILE: src/kmer_markov_composition_vector.sv
`timescale 1ns / 1ps
// k-mer composition counter with Markov-subtracted query results.
// Input channel (in_valid / in_stall) takes one request per accept: a symbol,
// an end of gene, a query or a table clear. Only queries produce a result on
// the output channel (out_valid / out_stall); the others produce nothing.
// A symbol request is read, then the three histograms get a saturating
// increment; an end of gene needs only the accept; a clear starts the
// zeroing sweep over the k-mer table. A query whose (k-1)-mer counts are not
// both nonzero goes straight to the result; a full query is paced by the shared
// 32x32 word multiplier (six products of six words) and the 33-step restoring
// divider. The result sits in an output register; further symbols are taken
// while it waits, a later query holds until the receiver takes it.
// Reset (rst_n low, synchronous) sets the word length to 3, clears totals and
// window, then runs the same clearing sweep with in_stall high.
// Configuration writes (cfg_valid, cfg_ready always high) are taken at any time
// and must only be issued while the block is idle.
module kmer_markov_composition_vector
  import kmcv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_W-1:0]        cfg_kmer_length,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_cmd,
  input  logic [1:0]              in_symbol,
  input  logic [15:0]             in_kmer_index,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CNT_W-1:0]        out_kmer_count,
  output logic signed [CNT_W-1:0] out_cv_value,
  output logic                    out_cv_valid
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // the register is a plain flop: always take the write
  assign cfg_ready = 1'b1;

  kmcv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  kmcv_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_kmer_length (cfg_kmer_length),
    .in_cmd          (in_cmd),
    .in_symbol       (in_symbol),
    .in_kmer_index   (in_kmer_index),
    .out_stall       (out_stall),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_kmer_count  (out_kmer_count),
    .out_cv_value    (out_cv_value),
    .out_cv_valid    (out_cv_valid)
  );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Bench for the k-mer composition counter.
// A driver feeds requests (symbol, end of gene, query, clear) from a pending
// queue in random bursts. At each accepted request a local copy of the
// histograms and window totals is advanced. Each query pushes the expected
// count, Markov value and valid flag. A monitor takes results under a
// random stall pattern and checks them in order.
module tb_top;
  import kmcv_pkg::*;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  symbol;
    logic [15:0] kmer_index;
  } request_t;

  typedef struct packed {
    logic [31:0] kmer_count;
    logic [31:0] cv_value;
    logic        cv_valid;
  } query_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_kmer_length = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = '0;
  logic [1:0] in_symbol = '0;
  logic [15:0] in_kmer_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CNT_W-1:0] out_kmer_count;
  logic signed [CNT_W-1:0] out_cv_value;
  logic out_cv_valid;

  always #2 clk = ~clk;

  kmer_markov_composition_vector u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_kmer_length(cfg_kmer_length),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_symbol(in_symbol), .in_kmer_index(in_kmer_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_kmer_count(out_kmer_count),
    .out_cv_value(out_cv_value), .out_cv_valid(out_cv_valid)
  );

  // Shadow state of the block.
  int unsigned kmer_tab [65536];
  int unsigned kmer1_tab [16384];
  int unsigned kmer2_tab [4096];
  int unsigned win_totals [3];
  logic [15:0] win_hist = '0;
  int unsigned win_fill;
  logic [CFG_W-1:0] word_len = CFG_W'(MIN_K);

  request_t pending_q[$];
  query_result_t results_due[$];
  int unsigned errors = 0;
  int unsigned n_sent = 0, n_queries = 0, n_clears = 0, n_checked = 0, n_settings = 0;
  bit hold_req = 0;
  logic [15:0] gen_hist = '0;

  function automatic int unsigned eff_len(input logic [CFG_W-1:0] v);
    if (v < MIN_K) return MIN_K;
    if (v > MAX_K) return MAX_K;
    return v;
  endfunction

  function automatic logic [15:0] len_mask(input int unsigned len);
    logic [16:0] m;
    m = (17'd1 << (2 * len)) - 17'd1;
    return m[15:0];
  endfunction

  function automatic int unsigned bump(input int unsigned v);
    return (v == 32'hFFFF_FFFF) ? v : v + 1;
  endfunction

  task automatic wipe_tables();
    foreach (kmer_tab[i]) kmer_tab[i] = 0;
    foreach (kmer1_tab[i]) kmer1_tab[i] = 0;
    foreach (kmer2_tab[i]) kmer2_tab[i] = 0;
    win_totals = '{0, 0, 0};
    win_hist = '0;
    win_fill = 0;
  endtask

  // Exact (n*den - num) * 2^16 / num, floored, saturated at the top.
  function automatic logic [31:0] markov_q16(input int unsigned n, input int unsigned ca,
                                             input int unsigned cb, input int unsigned cm);
    logic [191:0] num, rem, quo;
    num = {160'b0, win_totals[0]} * {160'b0, win_totals[2]} * {160'b0, cb} * {160'b0, ca};
    if (num == 0) return CV_MAX;
    rem = ({160'b0, win_totals[1]} * {160'b0, win_totals[1]} * {160'b0, cm}
           * {160'b0, n}) << 16;
    if (rem >= (num << 33)) return CV_MAX;
    quo = rem / num;
    if (quo > 192'h8000_FFFF) return CV_MAX;
    quo = quo - 192'd65536;
    return quo[31:0];
  endfunction

  task automatic apply_request(input request_t r);
    int unsigned k, len, idx, ia, ib, im;
    query_result_t res;
    k = eff_len(word_len);
    case (r.cmd)
      CMD_SYMBOL: begin
        win_hist = {win_hist[13:0], r.symbol};
        if (win_fill < MAX_K) win_fill++;
        for (int j = 0; j < 3; j++) begin
          len = k - j;
          if (win_fill >= len) begin
            idx = win_hist & len_mask(len);
            if (j == 0) kmer_tab[idx] = bump(kmer_tab[idx]);
            else if (j == 1) kmer1_tab[idx] = bump(kmer1_tab[idx]);
            else kmer2_tab[idx] = bump(kmer2_tab[idx]);
            win_totals[j] = bump(win_totals[j]);
          end
        end
      end
      CMD_EOG: begin
        win_hist = '0;
        win_fill = 0;
      end
      CMD_CLEAR: wipe_tables();
      default: begin
        idx = r.kmer_index & len_mask(k);
        ib = (idx >> 2) & 16'h3FFF;
        ia = idx & len_mask(k - 1);
        im = (idx >> 2) & len_mask(k - 2);
        res.kmer_count = kmer_tab[idx];
        res.cv_valid = (kmer1_tab[ia] != 0) && (kmer1_tab[ib] != 0);
        res.cv_value = res.cv_valid ?
            markov_q16(kmer_tab[idx], kmer1_tab[ia], kmer1_tab[ib], kmer2_tab[im]) : '0;
        results_due.push_back(res);
        n_queries++;
      end
    endcase
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
  endtask

  // Driver: advance only when the current request is taken; bursts and gaps.
  int unsigned burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    request_t r;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        apply_request('{in_cmd, in_symbol, in_kmer_index});
        n_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_q.size() > 0) begin
          r = pending_q.pop_front();
          in_cmd <= r.cmd;
          in_symbol <= r.symbol;
          in_kmer_index <= r.kmer_index;
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern: a free-running counter redraws the stall mode; a
  // requested long hold keeps stall high so the block backs up.
  int unsigned stall_cyc = 0, stall_mode = 0, hold_left = 0;
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1;
    if (stall_cyc % 64 == 0) stall_mode <= $urandom_range(0, 2);
    if (hold_req && hold_left == 0) begin
      hold_req = 0;
      hold_left <= 600;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // Monitor: compare each taken result with the oldest expectation.
  always @(posedge clk) begin
    query_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        report("unexpected result", out_kmer_count, '0);
      end else begin
        want = results_due.pop_front();
        n_checked++;
        if (out_kmer_count !== want.kmer_count)
          report("kmer_count", out_kmer_count, want.kmer_count);
        if (out_cv_value !== want.cv_value)
          report("cv_value", out_cv_value, want.cv_value);
        if (out_cv_valid !== want.cv_valid)
          report("cv_valid", {31'b0, out_cv_valid}, {31'b0, want.cv_valid});
      end
    end
  end

  task automatic push_req(input logic [1:0] cmd, input logic [1:0] sym, input logic [15:0] idx);
    pending_q.push_back('{cmd, sym, idx});
    if (cmd == CMD_SYMBOL) gen_hist = {gen_hist[13:0], sym};
    if (cmd == CMD_CLEAR) n_clears++;
  endtask

  // Hold until all requests are taken and every result is back.
  task automatic wait_drained();
    do @(posedge clk); while (pending_q.size() != 0 || in_valid || results_due.size() != 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_len(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_kmer_length <= v;
    do @(posedge clk); while (!cfg_ready);
    word_len = v;
    n_settings++;
    cfg_valid <= 1'b0;
  endtask

  // Mostly symbols in genes, queries aimed at recently seen words.
  task automatic push_random(input int count, input int q_pct);
    int p;
    logic [15:0] m, idx;
    m = len_mask(eff_len(word_len));
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(0, 99);
      idx = 16'($urandom);
      if (p < 100 - q_pct - 8) begin
        push_req(CMD_SYMBOL, 2'($urandom), idx);
      end else if (p < 100 - q_pct) begin
        push_req(CMD_EOG, 2'($urandom), idx);
      end else begin
        if ($urandom_range(0, 9) < 6) idx = (idx & ~m) | (gen_hist & m);
        push_req(CMD_QUERY, 2'($urandom), idx);
      end
    end
    push_req(CMD_QUERY, 2'($urandom), (gen_hist & m) | (16'($urandom) & ~m));
  endtask

  initial begin
    logic [CFG_W-1:0] lens [9] = '{4'd8, 4'd0, 4'd15, 4'd5, 4'd2, 4'd4, 4'd7, 4'd3, 4'd6};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (in_stall);
    write_len(4'd3);

    // Directed: empty tables, full alphabet, short gene, masked index bits,
    // valid neighbours with no k-window (numerator zero), clear.
    push_req(CMD_QUERY, 2'd0, 16'h0000);
    push_req(CMD_SYMBOL, 2'd0, 16'hFFFF);
    push_req(CMD_SYMBOL, 2'd1, 16'h0000);
    push_req(CMD_SYMBOL, 2'd2, 16'h0000);
    push_req(CMD_SYMBOL, 2'd3, 16'h0000);
    push_req(CMD_SYMBOL, 2'd3, 16'h0000);
    push_req(CMD_SYMBOL, 2'd2, 16'h0000);
    push_req(CMD_SYMBOL, 2'd1, 16'h0000);
    push_req(CMD_SYMBOL, 2'd0, 16'h0000);
    push_req(CMD_QUERY, 2'd3, 16'h0006);
    push_req(CMD_QUERY, 2'd0, 16'hFFFF);
    push_req(CMD_QUERY, 2'd0, 16'hFFC0);
    push_req(CMD_EOG, 2'd3, 16'hFFFF);
    push_req(CMD_SYMBOL, 2'd3, 16'h0000);
    push_req(CMD_SYMBOL, 2'd3, 16'h0000);
    push_req(CMD_EOG, 2'd0, 16'h0000);
    push_req(CMD_QUERY, 2'd0, 16'h003F);
    push_req(CMD_CLEAR, 2'd0, 16'h0000);
    push_req(CMD_SYMBOL, 2'd1, 16'h0000);
    push_req(CMD_SYMBOL, 2'd1, 16'h0000);
    push_req(CMD_EOG, 2'd0, 16'h0000);
    push_req(CMD_QUERY, 2'd0, 16'h0015);
    push_req(CMD_QUERY, 2'd0, 16'h0006);
    wait_drained();

    // Random phases over several word lengths; the odd-numbered phases start with a
    // clear, the others read counts left from the previous length.
    foreach (lens[i]) begin
      write_len(lens[i]);
      if (i % 2 == 1) push_req(CMD_CLEAR, 2'($urandom), 16'($urandom));
      if (i == 3) hold_req = 1;
      push_random(140, (i == 3) ? 40 : 20);
      wait_drained();
    end

    repeat (200) @(posedge clk);
    $display("covered %0d requests, %0d queries checked, %0d clears, %0d length settings",
             n_sent, n_checked, n_clears, n_settings);
    $display("word lengths written from 0 to 15, including the out-of-range values");
    if (errors == 0 && results_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
